// File: rtl/ow_pkg.sv
// Shared types, codes and register defaults for the 1-Wire bus master.
`default_nettype none

package ow_pkg;

  // Command codes carried in the op field of an input word.
  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_RESET = 3'd1,
    OP_WRITE = 3'd2,
    OP_READ  = 3'd3,
    OP_BIT   = 3'd4
  } op_t;

  // Slot sequencer phases.
  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_LOW    = 3'd1,
    PH_WAIT   = 3'd2,
    PH_SAMPLE = 3'd3,
    PH_REC    = 3'd4
  } phase_t;

  // Configuration register indexes.
  localparam logic [2:0] CFG_RESET_LOW     = 3'd0;
  localparam logic [2:0] CFG_PRESENCE_WAIT = 3'd1;
  localparam logic [2:0] CFG_SLOT_LONG     = 3'd2;
  localparam logic [2:0] CFG_SHORT_GAP     = 3'd3;
  localparam logic [2:0] CFG_READ_LOW      = 3'd4;
  localparam logic [2:0] CFG_READ_SAMPLE   = 3'd5;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;
  localparam int TIME_W     = 10;

  // Register defaults, in microseconds.
  localparam logic [9:0] RESET_LOW_DEF     = 10'd480;
  localparam logic [7:0] PRESENCE_WAIT_DEF = 8'd60;
  localparam logic [7:0] SLOT_LONG_DEF     = 8'd60;
  localparam logic [5:0] SHORT_GAP_DEF     = 6'd8;
  localparam logic [3:0] READ_LOW_DEF      = 4'd1;
  localparam logic [3:0] READ_SAMPLE_DEF   = 4'd3;

  typedef struct packed {
    logic [9:0] reset_low_us;
    logic [7:0] presence_wait_us;
    logic [7:0] slot_long_us;
    logic [5:0] short_gap_us;
    logic [3:0] read_low_us;
    logic [3:0] read_sample_us;
  } cfg_t;

  // Result of one tick.
  typedef struct packed {
    logic       drive_low;
    logic       busy;
    logic       done;
    logic       presence;
    logic [7:0] read_data;
    logic       rejected;
  } res_t;

  // A programmed length of zero counts as one tick.
  function automatic logic [TIME_W-1:0] at_least_one(input logic [TIME_W-1:0] v);
    at_least_one = (v == '0) ? TIME_W'(1) : v;
  endfunction

endpackage

`default_nettype wire

// File: rtl/ow_slot_seq.sv
// Slot sequencer: phase, timer, bit counter and shift byte, one tick per step.
`default_nettype none

module ow_slot_seq (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          step_en,
  input  wire logic [2:0]    op,
  input  wire logic [7:0]    data_byte,
  input  wire logic          line_level,
  input  ow_pkg::cfg_t       cfg,
  output ow_pkg::res_t       res,
  output logic               idle
);

  ow_pkg::phase_t                 phase_r, phase_nxt;
  ow_pkg::op_t                    kind_r, kind_nxt;
  logic [ow_pkg::TIME_W-1:0]      time_left_r, time_left_nxt;
  logic [3:0]                     bit_index_r, bit_index_nxt;
  logic [7:0]                     shift_r, shift_nxt;
  logic                           pres_r, pres_nxt;

  // Length of the low pulse that opens a slot.
  function automatic logic [ow_pkg::TIME_W-1:0] open_len(
    input ow_pkg::op_t  k,
    input logic         b,
    input ow_pkg::cfg_t c
  );
    logic [ow_pkg::TIME_W-1:0] v;
    case (k)
      ow_pkg::OP_RESET: v = c.reset_low_us;
      ow_pkg::OP_WRITE: v = b ? ow_pkg::TIME_W'(c.short_gap_us)
                              : ow_pkg::TIME_W'(c.slot_long_us);
      default:          v = ow_pkg::TIME_W'(c.read_low_us);
    endcase
    open_len = ow_pkg::at_least_one(v);
  endfunction

  assign idle = (phase_r == ow_pkg::PH_IDLE);

  always_comb begin
    logic is_cmd;
    logic finish;
    logic cur_bit;
    phase_nxt     = phase_r;
    kind_nxt      = kind_r;
    time_left_nxt = time_left_r;
    bit_index_nxt = bit_index_r;
    shift_nxt     = shift_r;
    pres_nxt      = pres_r;
    res           = '0;
    finish        = 1'b0;
    is_cmd        = (op == ow_pkg::OP_RESET) || (op == ow_pkg::OP_WRITE) ||
                    (op == ow_pkg::OP_READ)  || (op == ow_pkg::OP_BIT);

    if (phase_nxt == ow_pkg::PH_IDLE) begin
      if (is_cmd) begin
        kind_nxt      = ow_pkg::op_t'(op);
        bit_index_nxt = '0;
        shift_nxt     = (op == ow_pkg::OP_WRITE) ? data_byte : 8'd0;
        pres_nxt      = 1'b0;
        phase_nxt     = ow_pkg::PH_LOW;
        time_left_nxt = open_len(kind_nxt, shift_nxt[0], cfg);
      end
    end else if (is_cmd) begin
      res.rejected = 1'b1;
    end

    if (phase_nxt != ow_pkg::PH_IDLE) begin
      res.busy      = 1'b1;
      res.drive_low = (phase_nxt == ow_pkg::PH_LOW);
      if (phase_nxt == ow_pkg::PH_SAMPLE) begin
        if (kind_nxt == ow_pkg::OP_RESET) pres_nxt = ~line_level;
        else shift_nxt = shift_nxt | (8'(line_level) << bit_index_nxt[2:0]);
        phase_nxt = ow_pkg::PH_REC;
      end
      time_left_nxt = time_left_nxt - ow_pkg::TIME_W'(1);
      if (time_left_nxt == '0) begin
        cur_bit = shift_nxt[bit_index_nxt[2:0]];
        case (phase_nxt)
          ow_pkg::PH_LOW: begin
            if (kind_nxt == ow_pkg::OP_WRITE) begin
              phase_nxt     = ow_pkg::PH_REC;
              time_left_nxt = ow_pkg::at_least_one(cur_bit ?
                                ow_pkg::TIME_W'(cfg.slot_long_us) :
                                ow_pkg::TIME_W'(cfg.short_gap_us));
            end else begin
              phase_nxt     = ow_pkg::PH_WAIT;
              time_left_nxt = ow_pkg::at_least_one((kind_nxt == ow_pkg::OP_RESET) ?
                                ow_pkg::TIME_W'(cfg.presence_wait_us) :
                                ow_pkg::TIME_W'(cfg.read_sample_us));
            end
          end
          ow_pkg::PH_WAIT: begin
            phase_nxt     = ow_pkg::PH_SAMPLE;
            time_left_nxt = ow_pkg::at_least_one((kind_nxt == ow_pkg::OP_RESET) ?
                              cfg.reset_low_us : ow_pkg::TIME_W'(cfg.slot_long_us));
          end
          default: begin
            // end of recovery: reset and single-bit reads are complete
            if (kind_nxt == ow_pkg::OP_RESET || kind_nxt == ow_pkg::OP_BIT) begin
              finish = 1'b1;
            end else begin
              bit_index_nxt = bit_index_nxt + 4'd1;
              if (bit_index_nxt[3]) begin
                finish = 1'b1;
              end else begin
                phase_nxt     = ow_pkg::PH_LOW;
                time_left_nxt = open_len(kind_nxt, shift_nxt[bit_index_nxt[2:0]], cfg);
              end
            end
          end
        endcase
      end else begin
        cur_bit = 1'b0;
      end
      if (finish) begin
        res.done = 1'b1;
        if (kind_nxt == ow_pkg::OP_RESET) res.presence = pres_nxt;
        else if (kind_nxt == ow_pkg::OP_READ) res.read_data = shift_nxt;
        else if (kind_nxt == ow_pkg::OP_BIT) res.read_data = {7'd0, shift_nxt[0]};
        phase_nxt     = ow_pkg::PH_IDLE;
        time_left_nxt = '0;
      end
    end else begin
      cur_bit = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= ow_pkg::PH_IDLE;
      kind_r      <= ow_pkg::OP_NONE;
      time_left_r <= '0;
      bit_index_r <= '0;
      shift_r     <= '0;
      pres_r      <= 1'b0;
    end else if (step_en) begin
      phase_r     <= phase_nxt;
      kind_r      <= kind_nxt;
      time_left_r <= time_left_nxt;
      bit_index_r <= bit_index_nxt;
      shift_r     <= shift_nxt;
      pres_r      <= pres_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/one_wire_bus_master.sv
// Top level of the 1-Wire bus master: timing registers, slot sequencer, result register.
`default_nettype none

// One input word is one microsecond of bus time: the sampled line level plus an
// optional command (reset with presence detect, write byte, read byte, read bit).
// Every accepted word yields exactly one result word carrying the drive level,
// busy, a one-word done pulse and, on done, the presence flag or the read data.
// A command that arrives while an operation is running, including its done word,
// is dropped and flagged with rejected. Throughput is one word per clock but for
// input stalls; a result register gives the result in the cycle after its word
// is taken. Sequencer state (phase, 10-bit timer, bit counter, shift byte) steps
// once per word. The input side stalls only while a result waits and the output
// side stalls. The user must write timing registers through the cfg port only
// while no operation is running; the block does not enforce it. Each length is
// latched as its phase begins; a zero acts as one microsecond. No clearing pass.
module one_wire_bus_master (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input words
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [2:0]                    in_op,
  input  wire logic [7:0]                    in_data_byte,
  input  wire logic                          in_line_level,
  // result words
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_drive_low,
  output logic                               out_busy_res,
  output logic                               out_done_res,
  output logic                               out_presence,
  output logic [7:0]                         out_read_data,
  output logic                               out_rejected,
  // timing registers
  input  wire logic                          cfg_we,
  input  wire logic [ow_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ow_pkg::CFG_DATA_W-1:0] cfg_data
);

  ow_pkg::cfg_t cfg_r;
  ow_pkg::res_t step_res;
  ow_pkg::res_t res_r;
  logic         out_valid_r;
  logic         accept;
  logic         seq_idle;

  // Stall only while a held result cannot leave.
  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  // Timing registers; bits above each width are dropped, unknown indexes ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reset_low_us     <= ow_pkg::RESET_LOW_DEF;
      cfg_r.presence_wait_us <= ow_pkg::PRESENCE_WAIT_DEF;
      cfg_r.slot_long_us     <= ow_pkg::SLOT_LONG_DEF;
      cfg_r.short_gap_us     <= ow_pkg::SHORT_GAP_DEF;
      cfg_r.read_low_us      <= ow_pkg::READ_LOW_DEF;
      cfg_r.read_sample_us   <= ow_pkg::READ_SAMPLE_DEF;
    end else if (cfg_we) begin
      case (cfg_index)
        ow_pkg::CFG_RESET_LOW:     cfg_r.reset_low_us     <= cfg_data;
        ow_pkg::CFG_PRESENCE_WAIT: cfg_r.presence_wait_us <= cfg_data[7:0];
        ow_pkg::CFG_SLOT_LONG:     cfg_r.slot_long_us     <= cfg_data[7:0];
        ow_pkg::CFG_SHORT_GAP:     cfg_r.short_gap_us     <= cfg_data[5:0];
        ow_pkg::CFG_READ_LOW:      cfg_r.read_low_us      <= cfg_data[3:0];
        ow_pkg::CFG_READ_SAMPLE:   cfg_r.read_sample_us   <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Sequencer advances exactly one tick per accepted word.
  ow_slot_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (accept),
    .op         (in_op),
    .data_byte  (in_data_byte),
    .line_level (in_line_level),
    .cfg        (cfg_r),
    .res        (step_res),
    .idle       (seq_idle)
  );

  // Result register: loads on accept, drains when the far side takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= step_res;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_drive_low = res_r.drive_low;
  assign out_busy_res  = res_r.busy;
  assign out_done_res  = res_r.done;
  assign out_presence  = res_r.presence;
  assign out_read_data = res_r.read_data;
  assign out_rejected  = res_r.rejected;

  // A finishing tick leaves the sequencer idle for the next word.
  a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept && step_res.done |=> seq_idle)
    else $error("sequencer not idle after done");

  // Presence and read data are only reported with done.
  a_payload_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_presence || out_read_data != 8'd0) |-> out_done_res)
    else $error("presence or read data without done");

  // Bus is pulled low and commands are rejected only while an operation runs.
  a_drive_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_drive_low || out_rejected) |-> out_busy_res)
    else $error("drive or reject while not busy");

  // An idle sequencer never rejects the command it is handed.
  a_idle_accepts: assert property (@(posedge clk) disable iff (!rst_n)
    accept && seq_idle |-> !step_res.rejected)
    else $error("command rejected while idle");

endmodule

`default_nettype wire

// File: sim/one_wire_bus_master_tb.sv
// Self-checking testbench for the 1-Wire bus master: tick predictor, random traffic, timing sweeps.
module one_wire_bus_master_tb;

  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_REPORTS = 40;

  // Line level patterns for the ticks of one operation.
  localparam logic [1:0] LV_LOW  = 2'd0;
  localparam logic [1:0] LV_HIGH = 2'd1;
  localparam logic [1:0] LV_RAND = 2'd2;

  // Indexes past the last timing register; writes there must be dropped.
  localparam logic [2:0] CFG_SPARE_A = 3'd6;
  localparam logic [2:0] CFG_SPARE_B = 3'd7;

  // One bus tick as handed to the block.
  typedef struct packed {
    logic [2:0] op;
    logic [7:0] dbyte;
    logic       lvl;
  } bus_word_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [2:0] in_op = ow_pkg::OP_NONE;
  logic [7:0] in_data_byte = 8'h00;
  logic       in_line_level = 1'b1;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_drive_low;
  logic       out_busy_res;
  logic       out_done_res;
  logic       out_presence;
  logic [7:0] out_read_data;
  logic       out_rejected;
  logic       cfg_we = 1'b0;
  logic [ow_pkg::CFG_IDX_W-1:0]  cfg_index = ow_pkg::CFG_RESET_LOW;
  logic [ow_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  one_wire_bus_master DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_op         (in_op),
    .in_data_byte  (in_data_byte),
    .in_line_level (in_line_level),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_drive_low (out_drive_low),
    .out_busy_res  (out_busy_res),
    .out_done_res  (out_done_res),
    .out_presence  (out_presence),
    .out_read_data (out_read_data),
    .out_rejected  (out_rejected),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state: timing registers plus the slot sequencer.
  // ---------------------------------------------------------------------------
  ow_pkg::cfg_t   tmg;
  ow_pkg::phase_t seq_ph;
  ow_pkg::op_t    cur_op;
  logic [9:0]     ticks_left;
  logic [3:0]     bit_pos;
  logic [7:0]     shreg;
  logic           pres_flag;

  bus_word_t    tick_word_q[$];   // words waiting for the driver
  ow_pkg::res_t tick_res_q[$];    // predicted results, oldest first
  bus_word_t    drv_word;
  ow_pkg::res_t pred_res;
  ow_pkg::res_t exp_res;

  logic in_took = 1'b0;         // word taken at the last rising edge
  logic steady = 1'b0;          // no idling on either side
  logic hold_go = 1'b0;         // request one long receiver hold-off
  logic hold_used = 1'b0;
  int   hold_left = 0;

  int cyc = 0;
  int n_queued = 0;
  int n_taken = 0;
  int n_checked = 0;
  int n_err = 0;
  int n_done = 0;
  int n_pres = 0;
  int n_rej = 0;
  int n_phases = 0;

  // A programmed length of zero runs for one tick.
  function automatic logic [9:0] nz_len(input logic [9:0] v);
    return (v == 10'd0) ? 10'd1 : v;
  endfunction

  // Opens the low part of the next slot of the current operation.
  function automatic void slot_open();
    seq_ph = ow_pkg::PH_LOW;
    case (cur_op)
      ow_pkg::OP_RESET: ticks_left = nz_len(tmg.reset_low_us);
      ow_pkg::OP_WRITE: ticks_left = nz_len(shreg[bit_pos[2:0]] ? 10'(tmg.short_gap_us)
                                                                 : 10'(tmg.slot_long_us));
      default:          ticks_left = nz_len(10'(tmg.read_low_us));
    endcase
  endfunction

  // Result of one microsecond tick; advances the sequencer copy.
  function automatic ow_pkg::res_t predict_tick(input logic [2:0] op, input logic [7:0] dbyte,
                                                input logic lvl);
    ow_pkg::res_t r;
    logic is_cmd;
    logic fin;
    r = '0;
    fin = 1'b0;
    is_cmd = (op >= ow_pkg::OP_RESET) && (op <= ow_pkg::OP_BIT);
    if (seq_ph == ow_pkg::PH_IDLE) begin
      if (is_cmd) begin
        cur_op = ow_pkg::op_t'(op);
        bit_pos = 4'd0;
        shreg = (op == ow_pkg::OP_WRITE) ? dbyte : 8'h00;
        pres_flag = 1'b0;
        slot_open();
      end
    end else if (is_cmd) begin
      r.rejected = 1'b1;   // busy, including the done tick
    end
    if (seq_ph != ow_pkg::PH_IDLE) begin
      r.busy = 1'b1;
      r.drive_low = (seq_ph == ow_pkg::PH_LOW);
      if (seq_ph == ow_pkg::PH_SAMPLE) begin
        // first recovery tick: presence is a low line, a read bit is the level
        if (cur_op == ow_pkg::OP_RESET) pres_flag = ~lvl;
        else shreg[bit_pos[2:0]] = shreg[bit_pos[2:0]] | lvl;
        seq_ph = ow_pkg::PH_REC;
      end
      ticks_left = ticks_left - 10'd1;
      if (ticks_left == 10'd0) begin
        case (seq_ph)
          ow_pkg::PH_LOW: begin
            if (cur_op == ow_pkg::OP_WRITE) begin
              seq_ph = ow_pkg::PH_REC;
              ticks_left = nz_len(shreg[bit_pos[2:0]] ? 10'(tmg.slot_long_us)
                                                      : 10'(tmg.short_gap_us));
            end else begin
              seq_ph = ow_pkg::PH_WAIT;
              ticks_left = nz_len((cur_op == ow_pkg::OP_RESET) ? 10'(tmg.presence_wait_us)
                                                               : 10'(tmg.read_sample_us));
            end
          end
          ow_pkg::PH_WAIT: begin
            seq_ph = ow_pkg::PH_SAMPLE;
            ticks_left = nz_len((cur_op == ow_pkg::OP_RESET) ? tmg.reset_low_us
                                                             : 10'(tmg.slot_long_us));
          end
          default: begin
            if (cur_op == ow_pkg::OP_RESET || cur_op == ow_pkg::OP_BIT) begin
              fin = 1'b1;
            end else begin
              bit_pos = bit_pos + 4'd1;
              if (bit_pos >= 4'd8) fin = 1'b1;
              else slot_open();
            end
          end
        endcase
        if (fin) begin
          r.done = 1'b1;
          if (cur_op == ow_pkg::OP_RESET) r.presence = pres_flag;
          else if (cur_op == ow_pkg::OP_READ) r.read_data = shreg;
          else if (cur_op == ow_pkg::OP_BIT) r.read_data = {7'd0, shreg[0]};
          seq_ph = ow_pkg::PH_IDLE;
          ticks_left = 10'd0;
        end
      end
    end
    return r;
  endfunction

  task automatic chk_field(input string nm, input logic [7:0] e, input logic [7:0] g);
    if (g !== e) begin
      n_err++;
      if (n_err <= MAX_REPORTS) $error("%s: expected %0h, got %0h", nm, e, g);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: timeout, predictor update on every taken word, result check.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cyc = cyc + 1;
    if (cyc > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      in_took = rst_n && in_valid && !in_stall;
      if (!rst_n) begin
        tmg.reset_low_us = ow_pkg::RESET_LOW_DEF;
        tmg.presence_wait_us = ow_pkg::PRESENCE_WAIT_DEF;
        tmg.slot_long_us = ow_pkg::SLOT_LONG_DEF;
        tmg.short_gap_us = ow_pkg::SHORT_GAP_DEF;
        tmg.read_low_us = ow_pkg::READ_LOW_DEF;
        tmg.read_sample_us = ow_pkg::READ_SAMPLE_DEF;
        seq_ph = ow_pkg::PH_IDLE;
        cur_op = ow_pkg::OP_NONE;
        ticks_left = 10'd0;
        bit_pos = 4'd0;
        shreg = 8'h00;
        pres_flag = 1'b0;
      end else begin
        if (cfg_we) begin
          // bits above a register's width are dropped, spare indexes ignored
          case (cfg_index)
            ow_pkg::CFG_RESET_LOW:     tmg.reset_low_us = cfg_data;
            ow_pkg::CFG_PRESENCE_WAIT: tmg.presence_wait_us = cfg_data[7:0];
            ow_pkg::CFG_SLOT_LONG:     tmg.slot_long_us = cfg_data[7:0];
            ow_pkg::CFG_SHORT_GAP:     tmg.short_gap_us = cfg_data[5:0];
            ow_pkg::CFG_READ_LOW:      tmg.read_low_us = cfg_data[3:0];
            ow_pkg::CFG_READ_SAMPLE:   tmg.read_sample_us = cfg_data[3:0];
            default: ;
          endcase
        end
        if (in_took) begin
          pred_res = predict_tick(in_op, in_data_byte, in_line_level);
          tick_res_q.push_back(pred_res);
          n_taken++;
          n_done += int'(pred_res.done);
          n_pres += int'(pred_res.presence);
          n_rej += int'(pred_res.rejected);
        end
        if (out_valid && !out_stall) begin
          n_checked++;
          if (tick_res_q.size() == 0) begin
            n_err++;
            if (n_err <= MAX_REPORTS) $error("result word with no prediction pending");
          end else begin
            exp_res = tick_res_q.pop_front();
            chk_field("drive_low", 8'(exp_res.drive_low), 8'(out_drive_low));
            chk_field("busy_res", 8'(exp_res.busy), 8'(out_busy_res));
            chk_field("done_res", 8'(exp_res.done), 8'(out_done_res));
            chk_field("presence", 8'(exp_res.presence), 8'(out_presence));
            chk_field("read_data", exp_res.read_data, out_read_data);
            chk_field("rejected", 8'(exp_res.rejected), 8'(out_rejected));
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: next word at the falling edge once the previous one was taken.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!in_valid || in_took) begin
      if (rst_n && tick_word_q.size() != 0 && (steady || $urandom_range(99) >= 24)) begin
        drv_word = tick_word_q.pop_front();
        in_valid <= 1'b1;
        in_op <= drv_word.op;
        in_data_byte <= drv_word.dbyte;
        in_line_level <= drv_word.lvl;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off so the result register
  // fills and the block has to stall its input.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_go && !hold_used) begin
      hold_used = 1'b1;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !steady && ($urandom_range(99) < 24);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_word(input logic [2:0] op, input logic [7:0] d, input logic lv);
    bus_word_t w;
    w.op = op;
    w.dbyte = d;
    w.lvl = lv;
    tick_word_q.push_back(w);
    n_queued++;
  endtask

  // Ticks an operation occupies under the current timing.
  function automatic int op_span(input logic [2:0] op);
    int rl, pw, sl, sg, rdl, rs;
    rl = int'(nz_len(tmg.reset_low_us));
    pw = int'(nz_len(10'(tmg.presence_wait_us)));
    sl = int'(nz_len(10'(tmg.slot_long_us)));
    sg = int'(nz_len(10'(tmg.short_gap_us)));
    rdl = int'(nz_len(10'(tmg.read_low_us)));
    rs = int'(nz_len(10'(tmg.read_sample_us)));
    case (op)
      ow_pkg::OP_RESET: return 2 * rl + pw;
      ow_pkg::OP_WRITE: return 8 * (sl + sg);   // a 1 and a 0 slot last the same
      ow_pkg::OP_READ:  return 8 * (rdl + rs + sl);
      ow_pkg::OP_BIT:   return rdl + rs + sl;
      default:          return 1;
    endcase
  endfunction

  // Command word followed by its ticks. extra < 0 lets the next command land
  // while busy (-1 hits the done tick); extra > 0 leaves idle ticks after.
  task automatic push_op(input logic [2:0] op, input logic [7:0] d, input logic [1:0] mode,
                         input int extra);
    int span;
    logic [2:0] nop;
    logic lv;
    span = op_span(op);
    lv = (mode == LV_RAND) ? 1'($urandom_range(1)) : mode[0];
    queue_word(op, d, lv);
    for (int k = 0; k < span - 1 + extra; k++) begin
      nop = ow_pkg::OP_NONE;
      if (k < span - 2 && $urandom_range(99) < 3) begin
        nop = 3'($urandom_range(ow_pkg::OP_RESET, ow_pkg::OP_BIT));
      end else if ($urandom_range(99) < 8) begin
        nop = 3'($urandom_range(5, 7));   // unknown codes
      end
      lv = (mode == LV_RAND) ? 1'($urandom_range(1)) : mode[0];
      queue_word(nop, 8'($urandom), lv);
    end
  endtask

  task automatic run_random(input int nwords);
    int stop_at;
    int r;
    int extra;
    logic [2:0] op;
    logic [1:0] mode;
    stop_at = n_queued + nwords;
    while (n_queued < stop_at) begin
      r = $urandom_range(99);
      op = (r < 10) ? ow_pkg::OP_RESET : (r < 45) ? ow_pkg::OP_WRITE :
           (r < 75) ? ow_pkg::OP_READ : ow_pkg::OP_BIT;
      r = $urandom_range(99);
      mode = (r < 10) ? LV_LOW : (r < 20) ? LV_HIGH : LV_RAND;
      r = $urandom_range(99);
      if (r < 72) extra = 0;
      else if (r < 80) extra = -1;
      else if (r < 88) extra = -int'($urandom_range(2, 12));
      else extra = int'($urandom_range(1, 6));
      push_op(op, 8'($urandom), mode, extra);
    end
  endtask

  task automatic drain();
    do @(negedge clk); while (n_taken != n_queued || n_checked != n_taken);
  endtask

  // Every result in, sequencer idle, then spare cycles before the next step.
  task automatic quiesce();
    drain();
    while (seq_ph != ow_pkg::PH_IDLE) begin
      repeat (16) queue_word(ow_pkg::OP_NONE, 8'($urandom), 1'($urandom_range(1)));
      drain();
    end
    repeat (2) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [9:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_timing(input int rl, input int pw, input int sl, input int sg,
                            input int rdl, input int rs);
    cfg_write(ow_pkg::CFG_RESET_LOW, 10'(rl));
    cfg_write(ow_pkg::CFG_PRESENCE_WAIT, 10'(pw));
    cfg_write(ow_pkg::CFG_SLOT_LONG, 10'(sl));
    cfg_write(ow_pkg::CFG_SHORT_GAP, 10'(sg));
    cfg_write(ow_pkg::CFG_READ_LOW, 10'(rdl));
    cfg_write(ow_pkg::CFG_READ_SAMPLE, 10'(rs));
  endtask

  // Flags change at a rising edge so the falling-edge processes see them cleanly.
  task automatic begin_phase(input logic st, input logic hg);
    @(posedge clk);
    steady = st;
    hold_go = hg;
    n_phases++;
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Power-up timing: a bit read on the default read slot, idle unknown codes.
    begin_phase(1'b0, 1'b0);
    push_op(ow_pkg::OP_BIT, 8'hFF, LV_LOW, 0);
    for (int k = 5; k < 8; k++) queue_word(3'(k), 8'hFF, 1'b1);
    quiesce();

    // Short slots: presence and none, byte extremes, read all low / all high,
    // collisions.
    set_timing(3, 2, 3, 1, 1, 2);
    begin_phase(1'b0, 1'b0);
    push_op(ow_pkg::OP_RESET, 8'h00, LV_LOW, 0);
    push_op(ow_pkg::OP_RESET, 8'h00, LV_HIGH, 0);
    push_op(ow_pkg::OP_WRITE, 8'h00, LV_RAND, 0);
    push_op(ow_pkg::OP_WRITE, 8'hFF, LV_RAND, 0);
    push_op(ow_pkg::OP_READ, 8'h00, LV_LOW, 0);
    push_op(ow_pkg::OP_READ, 8'h00, LV_HIGH, 0);
    push_op(ow_pkg::OP_BIT, 8'h00, LV_LOW, 0);
    push_op(ow_pkg::OP_READ, 8'h00, LV_RAND, -1);   // next command on the done tick
    push_op(ow_pkg::OP_WRITE, 8'h5A, LV_RAND, 0);
    push_op(ow_pkg::OP_RESET, 8'h00, LV_LOW, -4);   // next command mid reset
    push_op(ow_pkg::OP_BIT, 8'h00, LV_RAND, 0);
    run_random(60);
    quiesce();

    // Minimum lengths, back-to-back traffic with no idling.
    set_timing(1, 1, 1, 1, 1, 1);
    begin_phase(1'b1, 1'b0);
    run_random(200);
    quiesce();

    // Zero lengths act as one tick; spare indexes must not disturb anything.
    set_timing(0, 0, 0, 0, 0, 0);
    cfg_write(CFG_SPARE_A, 10'h3FF);
    cfg_write(CFG_SPARE_B, 10'h155);
    begin_phase(1'b0, 1'b0);
    run_random(160);
    quiesce();

    // Junk above the width of each register narrower than cfg_data; long receiver hold-off here.
    cfg_write(ow_pkg::CFG_RESET_LOW, 10'd9);
    cfg_write(ow_pkg::CFG_PRESENCE_WAIT, 10'h304);
    cfg_write(ow_pkg::CFG_SLOT_LONG, 10'h30A);
    cfg_write(ow_pkg::CFG_SHORT_GAP, 10'h3C3);
    cfg_write(ow_pkg::CFG_READ_LOW, 10'h3F2);
    cfg_write(ow_pkg::CFG_READ_SAMPLE, 10'h3F7);
    begin_phase(1'b0, 1'b1);
    run_random(300);
    quiesce();

    // Long presence wait and the widest read slot opening and sample wait.
    set_timing(4, 180, 40, 63, 15, 15);
    begin_phase(1'b0, 1'b0);
    push_op(ow_pkg::OP_RESET, 8'h00, LV_RAND, 0);
    push_op(ow_pkg::OP_BIT, 8'h00, LV_RAND, 0);
    quiesce();

    // A few random timing sets, zeros included.
    repeat (3) begin
      set_timing($urandom_range(0, 24), $urandom_range(0, 12), $urandom_range(0, 16),
                 $urandom_range(0, 8), $urandom_range(0, 5), $urandom_range(0, 6));
      begin_phase(1'b0, 1'b0);
      run_random(50);
      quiesce();
    end

    repeat (4) @(negedge clk);
    if (tick_res_q.size() != 0) begin
      n_err++;
      $error("%0d predicted results never arrived", tick_res_q.size());
    end
    $display("Ran %0d bus ticks over %0d timing phases: %0d operations finished,",
             n_taken, n_phases, n_done);
    $display("%0d resets saw presence, %0d commands bounced off a busy bus.", n_pres, n_rej);
    if (n_err == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
